### rtl/gddn_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date converter.
// No dependencies; every other file in rtl imports this package.
package gddn_pkg;

    localparam int PIPE_STAGES = 8;
    localparam int DN_W        = 22;

    localparam logic FUNC_TO_DAYNUM = 1'b0;
    localparam logic FUNC_TO_DATE   = 1'b1;

    localparam int DAYS_400 = 146097;
    localparam int DAYS_100 = 36524;
    localparam int DAYS_4   = 1461;
    localparam int DAYS_1   = 365;

    localparam logic [22:0] DAYNUM_MAX = 23'h3FFFFF;

    localparam int RCP400_SHIFT = 40;
    localparam longint unsigned RCP400 =
        ((64'd1 << RCP400_SHIFT) + 64'(DAYS_400) - 64'd1) / 64'(DAYS_400);
    localparam int RCP400_W = $clog2(RCP400 + 64'd1);
    localparam logic [RCP400_W-1:0] RCP400_K = RCP400_W'(RCP400);

    localparam int RCP4_SHIFT = 27;
    localparam longint unsigned RCP4 =
        ((64'd1 << RCP4_SHIFT) + 64'(DAYS_4) - 64'd1) / 64'(DAYS_4);
    localparam int RCP4_W = $clog2(RCP4 + 64'd1);
    localparam logic [RCP4_W-1:0] RCP4_K = RCP4_W'(RCP4);

    localparam int          RCP25_SHIFT  = 17;
    localparam logic [12:0] RCP25_K      = 13'd5243;
    localparam int          RCP25Q_SHIFT = 15;
    localparam logic [10:0] RCP25Q_K     = 11'd1311;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_YEAR  = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic        func;
        logic [13:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [21:0] day_number_in;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [21:0] day_number_out;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic        leap_flag;
    } rsp_t;

    typedef struct packed {
        logic [PIPE_STAGES-1:0] en;
        logic                   sel_dec;
    } pipe_ctl_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m > 4'd2) && (m <= 4'd12))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### rtl/gddn_ctrl.sv
// Pipeline control for the converter: valid bits, per-stage load enables and mode tag.
// Depends on gddn_pkg.
module gddn_ctrl
    import gddn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      func,
    input  logic      rsp_stall,
    output logic      req_stall,
    output logic      rsp_valid,
    output pipe_ctl_t ctl
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-2:0] func_reg;
    logic [PIPE_STAGES-2:0] func_next;
    logic [PIPE_STAGES-1:0] adv;

    always_comb
    begin
        adv[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || !rsp_stall;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? req_valid : valid_reg[0];
        func_next[0]  = adv[0] ? func : func_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
        for (int i = 1; i < PIPE_STAGES - 1; i++)
        begin
            func_next[i] = adv[i] ? func_reg[i-1] : func_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
    end

    assign req_stall   = !adv[0];
    assign rsp_valid   = valid_reg[PIPE_STAGES-1];
    assign ctl.en      = adv;
    assign ctl.sel_dec = (func_reg[PIPE_STAGES-2] == FUNC_TO_DATE);

endmodule

### rtl/gddn_enc.sv
// Date to day number path: range checks, leap test and day count over seven stages.
// Depends on gddn_pkg; load enables come from gddn_ctrl.
module gddn_enc
    import gddn_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  req_t      req,
    output rsp_t      rsp
);

    localparam logic [13:0] YEAR_MAX_V = 14'(YEAR_MAX);

    logic [13:0] e1_year_reg;
    logic [3:0]  e1_month_reg;
    logic [4:0]  e1_day_reg;
    logic        e1_bad_year_reg;
    logic        e1_bad_month_reg;
    logic [13:0] e1_p_reg;
    logic [22:0] e1_mul100_reg;
    logic [26:0] e1_mul25_reg;

    logic [13:0] e2_year_reg;
    logic [3:0]  e2_month_reg;
    logic [4:0]  e2_day_reg;
    status_t     e2_status_reg;
    logic        e2_leap_reg;
    logic [22:0] e2_d365_reg;
    logic [11:0] e2_corr_reg;

    logic [13:0] e3_year_reg;
    logic [3:0]  e3_month_reg;
    logic [4:0]  e3_day_reg;
    status_t     e3_status_reg;
    logic        e3_leap_reg;
    logic [22:0] e3_total_reg;

    rsp_t        e4_rsp_reg;
    rsp_t        e5_rsp_reg;
    rsp_t        e6_rsp_reg;
    rsp_t        e7_rsp_reg;

    logic [13:0] p;
    logic [11:0] q4p;
    logic [7:0]  c100;
    logic [5:0]  c400;
    logic [9:0]  y25;
    logic [13:0] rem25;
    logic        leap;
    logic        bad_day;
    status_t     status2;
    rsp_t        rsp4;

    always_comb
    begin
        p   = 14'(req.year_in - 14'd1);
        q4p = p[13:2];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            e1_year_reg      <= req.year_in;
            e1_month_reg     <= req.month_in;
            e1_day_reg       <= req.day_in;
            e1_bad_year_reg  <= (req.year_in == 14'd0) || (req.year_in > YEAR_MAX_V);
            e1_bad_month_reg <= (req.month_in == 4'd0) || (req.month_in > 4'd12);
            e1_p_reg         <= p;
            e1_mul100_reg    <= 23'(q4p) * 23'(RCP25Q_K);
            e1_mul25_reg     <= 27'(req.year_in) * 27'(RCP25_K);
        end
    end

    always_comb
    begin
        c100    = e1_mul100_reg[RCP25Q_SHIFT +: 8];
        c400    = c100[7:2];
        y25     = e1_mul25_reg[RCP25_SHIFT +: 10];
        rem25   = 14'(e1_year_reg - 14'(32'(y25) * 25));
        leap    = (e1_year_reg[1:0] == 2'b00)
                  && ((rem25 != 14'd0) || (e1_year_reg[3:0] == 4'd0));
        bad_day = (e1_day_reg == 5'd0) || (e1_day_reg > month_len(e1_month_reg, leap));
        if (e1_bad_year_reg)
        begin
            status2 = ST_BAD_YEAR;
        end
        else if (e1_bad_month_reg)
        begin
            status2 = ST_BAD_MONTH;
        end
        else if (bad_day)
        begin
            status2 = ST_BAD_DAY;
        end
        else
        begin
            status2 = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            e2_year_reg   <= e1_year_reg;
            e2_month_reg  <= e1_month_reg;
            e2_day_reg    <= e1_day_reg;
            e2_status_reg <= status2;
            e2_leap_reg   <= leap;
            e2_d365_reg   <= 23'(32'(e1_p_reg) * DAYS_1);
            e2_corr_reg   <= 12'(e1_p_reg[13:2] - 12'(c100) + 12'(c400));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            e3_year_reg   <= e2_year_reg;
            e3_month_reg  <= e2_month_reg;
            e3_day_reg    <= e2_day_reg;
            e3_status_reg <= e2_status_reg;
            e3_leap_reg   <= e2_leap_reg;
            e3_total_reg  <= 23'(e2_d365_reg + 23'(e2_corr_reg)
                                 + 23'(days_before_month(e2_month_reg, e2_leap_reg))
                                 + 23'(e2_day_reg) - 23'd1);
        end
    end

    always_comb
    begin
        rsp4 = '0;
        if ((e3_status_reg == ST_OK) && (e3_total_reg > DAYNUM_MAX))
        begin
            rsp4.status = ST_BAD_YEAR;
        end
        else if (e3_status_reg != ST_OK)
        begin
            rsp4.status = e3_status_reg;
        end
        else
        begin
            rsp4.status         = ST_OK;
            rsp4.day_number_out = e3_total_reg[21:0];
            rsp4.year_out       = e3_year_reg;
            rsp4.month_out      = e3_month_reg;
            rsp4.day_out        = e3_day_reg;
            rsp4.leap_flag      = e3_leap_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            e4_rsp_reg <= rsp4;
        end
        if (ctl.en[4])
        begin
            e5_rsp_reg <= e4_rsp_reg;
        end
        if (ctl.en[5])
        begin
            e6_rsp_reg <= e5_rsp_reg;
        end
        if (ctl.en[6])
        begin
            e7_rsp_reg <= e6_rsp_reg;
        end
    end

    assign rsp = e7_rsp_reg;

endmodule

### rtl/gddn_dec.sv
// Day number to date path: 400/100/4/1-year cycle split, leap test and month search.
// Depends on gddn_pkg; load enables come from gddn_ctrl.
module gddn_dec
    import gddn_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  req_t      req,
    output rsp_t      rsp
);

    localparam int LAST_DAY = YEAR_MAX * 365 + YEAR_MAX / 4 - YEAR_MAX / 100
                              + YEAR_MAX / 400 - 1;
    localparam logic [22:0] LAST_DAY_V = 23'(LAST_DAY);

    logic [DN_W-1:0]          s1_n_reg;
    logic                     s1_range_reg;
    logic [DN_W+RCP400_W-1:0] s1_prod_reg;

    logic [DN_W-1:0]          s2_n_reg;
    logic                     s2_range_reg;
    logic [4:0]               s2_q400_reg;
    logic [17:0]              s2_r0_reg;

    logic [DN_W-1:0]          s3_n_reg;
    logic                     s3_range_reg;
    logic [4:0]               s3_q400_reg;
    logic [1:0]               s3_q100_reg;
    logic [15:0]              s3_r1_reg;

    logic [DN_W-1:0]          s4_n_reg;
    logic                     s4_range_reg;
    logic [4:0]               s4_q400_reg;
    logic [1:0]               s4_q100_reg;
    logic [15:0]              s4_r1_reg;
    logic [16+RCP4_W-1:0]     s4_prod_reg;

    logic [DN_W-1:0]          s5_n_reg;
    logic                     s5_range_reg;
    logic [4:0]               s5_q400_reg;
    logic [1:0]               s5_q100_reg;
    logic [4:0]               s5_q4_reg;
    logic [10:0]              s5_r2_reg;

    logic [DN_W-1:0]          s6_n_reg;
    logic                     s6_range_reg;
    logic [13:0]              s6_year_reg;
    logic                     s6_leap_reg;
    logic [8:0]               s6_r3_reg;

    rsp_t                     s7_rsp_reg;

    logic [4:0]  q400;
    logic [1:0]  q100;
    logic [4:0]  q4;
    logic [1:0]  q1;
    logic [3:0]  mo;
    rsp_t        rsp7;

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            s1_n_reg     <= req.day_number_in;
            s1_range_reg <= ({1'b0, req.day_number_in} > LAST_DAY_V);
            s1_prod_reg  <= (DN_W+RCP400_W)'(req.day_number_in)
                            * (DN_W+RCP400_W)'(RCP400_K);
        end
    end

    always_comb
    begin
        q400 = s1_prod_reg[RCP400_SHIFT +: 5];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            s2_n_reg     <= s1_n_reg;
            s2_range_reg <= s1_range_reg;
            s2_q400_reg  <= q400;
            s2_r0_reg    <= 18'(32'(s1_n_reg) - 32'(q400) * DAYS_400);
        end
    end

    always_comb
    begin
        if (32'(s2_r0_reg) >= 3 * DAYS_100)
        begin
            q100 = 2'd3;
        end
        else if (32'(s2_r0_reg) >= 2 * DAYS_100)
        begin
            q100 = 2'd2;
        end
        else if (32'(s2_r0_reg) >= DAYS_100)
        begin
            q100 = 2'd1;
        end
        else
        begin
            q100 = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            s3_n_reg     <= s2_n_reg;
            s3_range_reg <= s2_range_reg;
            s3_q400_reg  <= s2_q400_reg;
            s3_q100_reg  <= q100;
            s3_r1_reg    <= 16'(32'(s2_r0_reg) - 32'(q100) * DAYS_100);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            s4_n_reg     <= s3_n_reg;
            s4_range_reg <= s3_range_reg;
            s4_q400_reg  <= s3_q400_reg;
            s4_q100_reg  <= s3_q100_reg;
            s4_r1_reg    <= s3_r1_reg;
            s4_prod_reg  <= (16+RCP4_W)'(s3_r1_reg) * (16+RCP4_W)'(RCP4_K);
        end
    end

    always_comb
    begin
        q4 = s4_prod_reg[RCP4_SHIFT +: 5];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[4])
        begin
            s5_n_reg     <= s4_n_reg;
            s5_range_reg <= s4_range_reg;
            s5_q400_reg  <= s4_q400_reg;
            s5_q100_reg  <= s4_q100_reg;
            s5_q4_reg    <= q4;
            s5_r2_reg    <= 11'(32'(s4_r1_reg) - 32'(q4) * DAYS_4);
        end
    end

    always_comb
    begin
        if (32'(s5_r2_reg) >= 3 * DAYS_1)
        begin
            q1 = 2'd3;
        end
        else if (32'(s5_r2_reg) >= 2 * DAYS_1)
        begin
            q1 = 2'd2;
        end
        else if (32'(s5_r2_reg) >= DAYS_1)
        begin
            q1 = 2'd1;
        end
        else
        begin
            q1 = 2'd0;
        end
    end

    // The last year of a four-year cycle is leap, except a century year
    // that does not close a 400-year cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.en[5])
        begin
            s6_n_reg     <= s5_n_reg;
            s6_range_reg <= s5_range_reg;
            s6_year_reg  <= 14'(400 * 32'(s5_q400_reg) + 100 * 32'(s5_q100_reg)
                                + 4 * 32'(s5_q4_reg) + 32'(q1) + 1);
            s6_leap_reg  <= (q1 == 2'd3) && ((s5_q4_reg != 5'd24) || (s5_q100_reg == 2'd3));
            s6_r3_reg    <= 9'(32'(s5_r2_reg) - 32'(q1) * DAYS_1);
        end
    end

    always_comb
    begin
        mo = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (s6_r3_reg >= days_before_month(4'(k), s6_leap_reg))
            begin
                mo = 4'(k);
            end
        end
        rsp7 = '0;
        if (s6_range_reg)
        begin
            rsp7.status = ST_RANGE;
        end
        else
        begin
            rsp7.status         = ST_OK;
            rsp7.day_number_out = s6_n_reg;
            rsp7.year_out       = s6_year_reg;
            rsp7.month_out      = mo;
            rsp7.day_out        = 5'(s6_r3_reg - days_before_month(mo, s6_leap_reg) + 9'd1);
            rsp7.leap_flag      = s6_leap_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[6])
        begin
            s7_rsp_reg <= rsp7;
        end
    end

    assign rsp = s7_rsp_reg;

endmodule

### rtl/gregorian_date_day_number_converter_core.sv
// Gregorian date / day number converter, top level. Depends on gddn_pkg and its submodules.
// Each request transfer passes through the eight-stage pipeline on its way to its response.
// Throughput: one transfer per cycle; a stalled response holds the pipeline in place and
// empty stages still fill, so no item is dropped or repeated.
// Reset clears all valid bits; data registers are not reset.
module gregorian_date_day_number_converter_core
    import gddn_pkg::*;
#(
    parameter int YEAR_MAX = 9999
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    pipe_ctl_t ctl;
    rsp_t      enc_rsp;
    rsp_t      dec_rsp;
    rsp_t      rsp_reg;

    gddn_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .func      (req.func),
        .rsp_stall (rsp_stall),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .ctl       (ctl)
    );

    gddn_enc #(
        .YEAR_MAX (YEAR_MAX)
    ) u_enc
    (
        .clk (clk),
        .ctl (ctl),
        .req (req),
        .rsp (enc_rsp)
    );

    gddn_dec #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dec
    (
        .clk (clk),
        .ctl (ctl),
        .req (req),
        .rsp (dec_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.en[PIPE_STAGES-1])
        begin
            rsp_reg <= ctl.sel_dec ? dec_rsp : enc_rsp;
        end
    end

    assign rsp = rsp_reg;

endmodule

### tb/gregorian_date_day_number_converter_core_tb.sv
// Self-checking testbench for the Gregorian date / day number converter core.
// Depends on gddn_pkg and the core; a local calendar model predicts every response.
`timescale 1ns / 1ps

module gregorian_date_day_number_converter_core_tb;
    import gddn_pkg::*;

    localparam int YEAR_MAX   = 9999;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 1925;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    req_t req_backlog[$];
    bit   drain_first[$];
    rsp_t rsp_due[$];

    logic req_taken;
    logic rsp_taken;
    int   req_gap;
    int   req_sent;
    int   rsp_hold;
    int   rsp_count;
    int   idle_cycles;
    int   err_cnt;

    gregorian_date_day_number_converter_core #(
        .YEAR_MAX(YEAR_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_to_year(input int unsigned y);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic int unsigned month_span(input int unsigned m, input logic leap);
        int unsigned len;
        case (m)
            2:             len = leap ? 29 : 28;
            4, 6, 9, 11:   len = 30;
            default:       len = 31;
        endcase
        return len;
    endfunction

    function automatic rsp_t convert_calendar(input req_t r);
        rsp_t        o;
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned t;
        int unsigned n;
        int unsigned q400;
        int unsigned q100;
        int unsigned q4;
        int unsigned q1;
        int unsigned k;
        int unsigned ml;
        logic        leap;
        o = '0;
        o.status = ST_OK;
        if (r.func == FUNC_TO_DAYNUM)
        begin
            y = 32'(r.year_in);
            m = 32'(r.month_in);
            d = 32'(r.day_in);
            if (y == 0 || y > YEAR_MAX)
            begin
                o.status = ST_BAD_YEAR;
            end
            else if (m == 0 || m > 12)
            begin
                o.status = ST_BAD_MONTH;
            end
            else
            begin
                leap = is_leap_year(y);
                if (d == 0 || d > month_span(m, leap))
                begin
                    o.status = ST_BAD_DAY;
                end
                else
                begin
                    t = days_to_year(y);
                    for (k = 1; k < m; k++)
                    begin
                        t += month_span(k, leap);
                    end
                    t += d - 1;
                    if (t > 32'h3FFFFF)
                    begin
                        o.status = ST_BAD_YEAR;
                    end
                    else
                    begin
                        o.day_number_out = 22'(t);
                        o.year_out       = 14'(y);
                        o.month_out      = 4'(m);
                        o.day_out        = 5'(d);
                        o.leap_flag      = leap;
                    end
                end
            end
        end
        else
        begin
            n = 32'(r.day_number_in);
            if (n > days_to_year(YEAR_MAX + 1) - 1)
            begin
                o.status = ST_RANGE;
            end
            else
            begin
                t = n;
                q400 = t / 146097;
                t = t % 146097;
                q100 = t / 36524;
                if (q100 > 3)
                begin
                    q100 = 3;
                end
                t = t - q100 * 36524;
                q4 = t / 1461;
                t = t % 1461;
                q1 = t / 365;
                if (q1 > 3)
                begin
                    q1 = 3;
                end
                t = t - q1 * 365;
                y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
                leap = is_leap_year(y);
                k = 1;
                ml = month_span(k, leap);
                while (k < 12 && t >= ml)
                begin
                    t -= ml;
                    k++;
                    ml = month_span(k, leap);
                end
                o.day_number_out = 22'(n);
                o.year_out       = 14'(y);
                o.month_out      = 4'(k);
                o.day_out        = 5'(t + 1);
                o.leap_flag      = leap;
            end
        end
        return o;
    endfunction

    function automatic req_t date_req(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        req_t r;
        r.func          = FUNC_TO_DAYNUM;
        r.year_in       = 14'(y);
        r.month_in      = 4'(m);
        r.day_in        = 5'(d);
        r.day_number_in = 22'($urandom);
        return r;
    endfunction

    function automatic req_t count_req(input int unsigned n);
        req_t r;
        r.func          = FUNC_TO_DATE;
        r.year_in       = 14'($urandom);
        r.month_in      = 4'($urandom);
        r.day_in        = 5'($urandom);
        r.day_number_in = 22'(n);
        return r;
    endfunction

    function void enqueue_item(input req_t r, input bit drain);
        req_backlog = {req_backlog, r};
        drain_first = {drain_first, drain};
    endfunction

    // Driver: a new item goes out only when the channel is empty or its last transfer completed.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (req_gap > 0)
                begin
                    req_valid <= 1'b0;
                    req_gap   <= req_gap - 1;
                end
                else if (req_backlog.size() != 0 &&
                         !(drain_first[0] && rsp_due.size() != 0))
                begin
                    req       <= req_backlog.pop_front();
                    void'(drain_first.pop_front());
                    req_valid <= 1'b1;
                    req_gap   <= (((req_sent / 150) % 3) == 2) ? 0 : $urandom_range(0, 3);
                    req_sent  = req_sent + 1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                rsp_hold = (((rsp_count / 150) % 3) == 2) ? 0 : $urandom_range(0, 3);
            end
            if (rsp_hold > 0)
            begin
                rsp_stall <= 1'b1;
                rsp_hold  = rsp_hold - 1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Monitor: predicts on every request transfer and checks every response transfer.
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            rsp_taken <= rsp_valid && !rsp_stall;
            if (req_valid && !req_stall)
            begin
                rsp_due = {rsp_due, convert_calendar(req)};
            end
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count = rsp_count + 1;
                if (rsp_due.size() == 0)
                begin
                    $error("response transfer with no request outstanding");
                    err_cnt = err_cnt + 1;
                end
                else
                begin
                    exp_rsp = rsp_due.pop_front();
                    if (rsp.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
                        err_cnt = err_cnt + 1;
                    end
                    if (rsp.day_number_out !== exp_rsp.day_number_out)
                    begin
                        $error("day_number_out: expected %0d, actual %0d",
                               exp_rsp.day_number_out, rsp.day_number_out);
                        err_cnt = err_cnt + 1;
                    end
                    if (rsp.year_out !== exp_rsp.year_out)
                    begin
                        $error("year_out: expected %0d, actual %0d",
                               exp_rsp.year_out, rsp.year_out);
                        err_cnt = err_cnt + 1;
                    end
                    if (rsp.month_out !== exp_rsp.month_out)
                    begin
                        $error("month_out: expected %0d, actual %0d",
                               exp_rsp.month_out, rsp.month_out);
                        err_cnt = err_cnt + 1;
                    end
                    if (rsp.day_out !== exp_rsp.day_out)
                    begin
                        $error("day_out: expected %0d, actual %0d",
                               exp_rsp.day_out, rsp.day_out);
                        err_cnt = err_cnt + 1;
                    end
                    if (rsp.leap_flag !== exp_rsp.leap_flag)
                    begin
                        $error("leap_flag: expected %0d, actual %0d",
                               exp_rsp.leap_flag, rsp.leap_flag);
                        err_cnt = err_cnt + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned last_day;
        int unsigned y;
        int unsigned m;
        int unsigned pick;
        req_t        r;
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_stall   = 1'b0;
        req_taken   = 1'b0;
        rsp_taken   = 1'b0;
        req_gap     = 0;
        req_sent    = 0;
        rsp_hold    = 0;
        rsp_count   = 0;
        idle_cycles = 0;
        err_cnt     = 0;
        last_day    = days_to_year(YEAR_MAX + 1) - 1;

        enqueue_item(date_req(1, 1, 1), 1'b0);
        enqueue_item(date_req(YEAR_MAX, 12, 31), 1'b0);
        enqueue_item(date_req(0, 1, 1), 1'b0);
        enqueue_item(date_req(YEAR_MAX + 1, 1, 1), 1'b0);
        enqueue_item(date_req(16383, 15, 31), 1'b0);
        enqueue_item(date_req(2000, 0, 1), 1'b0);
        enqueue_item(date_req(2000, 13, 1), 1'b0);
        enqueue_item(date_req(2000, 15, 0), 1'b0);
        enqueue_item(date_req(2000, 1, 0), 1'b0);
        enqueue_item(date_req(2001, 4, 31), 1'b0);
        enqueue_item(date_req(2000, 2, 29), 1'b0);
        enqueue_item(date_req(1900, 2, 29), 1'b0);
        enqueue_item(date_req(2024, 2, 29), 1'b0);
        enqueue_item(date_req(2023, 2, 29), 1'b0);
        enqueue_item(date_req(2024, 3, 1), 1'b0);
        enqueue_item(date_req(2100, 2, 28), 1'b0);
        enqueue_item(date_req(1, 1, 31), 1'b0);
        enqueue_item(count_req(0), 1'b0);
        enqueue_item(count_req(last_day), 1'b0);
        enqueue_item(count_req(last_day + 1), 1'b0);
        enqueue_item(count_req(32'h3FFFFF), 1'b0);
        enqueue_item(count_req(146096), 1'b0);
        enqueue_item(count_req(1460), 1'b0);
        enqueue_item(count_req(730119), 1'b0);
        enqueue_item(count_req(59), 1'b0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                y = $urandom_range(1, YEAR_MAX);
                m = $urandom_range(1, 12);
                r = date_req(y, m, $urandom_range(1, month_span(m, is_leap_year(y))));
            end
            else if (pick < 50)
            begin
                y = $urandom_range(1, YEAR_MAX / 4) * 4;
                r = date_req(y, 2, $urandom_range(28, 30));
            end
            else if (pick < 70)
            begin
                r = count_req($urandom_range(0, last_day));
            end
            else if (pick < 75)
            begin
                r = count_req($urandom_range(last_day - 2000, 32'h3FFFFF));
            end
            else
            begin
                r.func          = 1'($urandom);
                r.year_in       = 14'($urandom);
                r.month_in      = 4'($urandom);
                r.day_in        = 5'($urandom);
                r.day_number_in = 22'($urandom);
            end
            enqueue_item(r, i == 0 || i == 700 || i == 1400);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4 * PIPE_STAGES) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
